@@ rtl/tpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tpf_pkg - shared types and constants of the threshold pulse finder
// Register map, field widths, reset values and the types passed between
// the classifier front end, the transaction queue and the pulse back end.
// ----------------------------------------------------------------------------
package tpf_pkg;

   // default build parameters
   localparam int WINDOW_SAMPLES_DEF = 4096;
   localparam int ADC_BITS_DEF       = 14;
   localparam int FRAC_BITS_DEF      = 4;

   // fixed fraction bits of the sigma factors
   localparam int SIGMA_FRAC = 4;

   // register widths
   localparam int THR_W      = 18;
   localparam int FACTOR_W   = 8;
   localparam int BASELINE_W = 18;
   localparam int PED_RMS_W  = 16;

   // result field widths
   localparam int IDX_OUT_W = 12;
   localparam int PEAK_W    = 19;
   localparam int AREA_W    = 36;

   // threshold level: mean plus the larger of the absolute and sigma terms
   localparam int PROD_W  = FACTOR_W + PED_RMS_W;
   localparam int ABS_SW  = THR_W + SIGMA_FRAC;
   localparam int LEVEL_W = ((ABS_SW > PROD_W) ? ABS_SW : PROD_W) + 1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ABS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ABS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_FACTOR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PED_RMS      = 3'd5;

   // register reset values
   localparam logic [THR_W-1:0]      START_ABS_RST    = 18'd48;
   localparam logic [THR_W-1:0]      END_ABS_RST      = 18'd48;
   localparam logic [FACTOR_W-1:0]   START_FACTOR_RST = 8'd80;
   localparam logic [FACTOR_W-1:0]   END_FACTOR_RST   = 8'd80;
   localparam logic [BASELINE_W-1:0] BASELINE_RST     = 18'd0;
   localparam logic [PED_RMS_W-1:0]  PED_RMS_RST      = 16'd0;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // width of a pedestal-subtracted sample
   function automatic int diff_width(input int adc_bits, input int frac_bits);
      int scaled_w;
      scaled_w = adc_bits + frac_bits;
      return ((scaled_w > BASELINE_W) ? scaled_w : BASELINE_W) + 1;
   endfunction

   // classified sample, apart from its pedestal-subtracted value
   typedef struct packed {
      logic                 ge_start;
      logic                 lt_end;
      logic                 last;
      logic [IDX_OUT_W-1:0] idx;
      logic [IDX_OUT_W-1:0] start_cand;
      logic [PEAK_W-1:0]    peak;
   } item_ctl_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

@@ rtl/threshold_pulse_finder.sv @@
// ----------------------------------------------------------------------------
// threshold_pulse_finder - threshold pulse finder for one digitizer channel
// Path: a closing sample passes the stage register, the queue and the result register.
// Throughput: one sample per cycle unless a full queue or a result stall holds it.
// Reset: synchronous; registers return to their defaults, no pulse is open
// and the window index restarts at zero.
// ----------------------------------------------------------------------------
module threshold_pulse_finder #(
   parameter int WINDOW_SAMPLES = tpf_pkg::WINDOW_SAMPLES_DEF,
   parameter int ADC_BITS       = tpf_pkg::ADC_BITS_DEF,
   parameter int FRAC_BITS      = tpf_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ADC_BITS-1:0]                req_adc_sample,
   input  logic                               req_window_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tpf_pkg::IDX_OUT_W-1:0]      rsp_start_index,
   output logic [tpf_pkg::IDX_OUT_W-1:0]      rsp_end_index,
   output logic [tpf_pkg::IDX_OUT_W-1:0]      rsp_peak_index,
   output logic signed [tpf_pkg::PEAK_W-1:0]  rsp_peak_height,
   output logic signed [tpf_pkg::AREA_W-1:0]  rsp_pulse_area,
   input  logic                               csr_write_enable,
   input  logic [tpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpf_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import tpf_pkg::*;

   localparam int DIFF_W = diff_width(ADC_BITS, FRAC_BITS);
   localparam int Q_W    = $bits(item_ctl_type) + DIFF_W;

   queue_stat_type           q_stat;
   logic                     q_push;
   logic                     q_pop;
   item_ctl_type             f_ctl;
   logic signed [DIFF_W-1:0] f_diff;
   logic [Q_W-1:0]           q_rd_data;
   item_ctl_type             b_ctl;
   logic signed [DIFF_W-1:0] b_diff;

   // classify incoming samples
   tpf_front #(
      .WINDOW_SAMPLES(WINDOW_SAMPLES),
      .ADC_BITS(ADC_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_adc_sample(req_adc_sample),
      .req_window_end(req_window_end),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .q_stat(q_stat),
      .push(q_push),
      .cls_ctl(f_ctl),
      .cls_diff(f_diff)
   );

   // decouple front and back
   tpf_queue #(
      .WIDTH(Q_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .wr_data({f_ctl, f_diff}),
      .pop(q_pop),
      .rd_data(q_rd_data),
      .stat(q_stat)
   );

   assign b_ctl  = q_rd_data[Q_W-1:DIFF_W];
   assign b_diff = signed'(q_rd_data[DIFF_W-1:0]);

   // track pulses and emit results
   tpf_back #(
      .DIFF_W(DIFF_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_stat(q_stat),
      .pop(q_pop),
      .cls_ctl(b_ctl),
      .cls_diff(b_diff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_start_index(rsp_start_index),
      .rsp_end_index(rsp_end_index),
      .rsp_peak_index(rsp_peak_index),
      .rsp_peak_height(rsp_peak_height),
      .rsp_pulse_area(rsp_pulse_area)
   );

   // intake stalls only behind a full queue
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_stat.full)
      else $error("intake stalled while the queue had room");

   // a new result comes only from a popped transaction
   a_result_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop))
      else $error("result appeared without a queue pop");

   // peak is never negative
   a_peak_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_peak_height[PEAK_W-1])
      else $error("negative peak height reported");

   // no positive sample means no peak index
   a_zero_peak_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_peak_height == '0)) |-> (rsp_peak_index == '0))
      else $error("peak index set without a positive peak");

endmodule

@@ rtl/tpf_front.sv @@
// ----------------------------------------------------------------------------
// tpf_front - sample intake and classifier
// Holds the registers and thresholds, counts samples in the window, and
// classifies each accepted sample against the start and end levels.
// ----------------------------------------------------------------------------
module tpf_front #(
   parameter int WINDOW_SAMPLES = tpf_pkg::WINDOW_SAMPLES_DEF,
   parameter int ADC_BITS       = tpf_pkg::ADC_BITS_DEF,
   parameter int FRAC_BITS      = tpf_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ADC_BITS-1:0]                  req_adc_sample,
   input  logic                                 req_window_end,
   input  logic                                 csr_write_enable,
   input  logic [tpf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tpf_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  tpf_pkg::queue_stat_type              q_stat,
   output logic                                 push,
   output tpf_pkg::item_ctl_type                cls_ctl,
   output logic signed [tpf_pkg::diff_width(ADC_BITS, FRAC_BITS)-1:0] cls_diff
);
   import tpf_pkg::*;

   localparam int IDX_W   = $clog2(WINDOW_SAMPLES);
   localparam int SCALE_W = ADC_BITS + FRAC_BITS + SIGMA_FRAC;
   localparam int CMP_W   = (SCALE_W > LEVEL_W) ? SCALE_W : LEVEL_W;
   localparam int DIFF_W  = diff_width(ADC_BITS, FRAC_BITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);
   localparam logic signed [DIFF_W-1:0] PEAK_HI = DIFF_W'((2 ** (PEAK_W - 1)) - 1);
   localparam logic signed [DIFF_W-1:0] PEAK_LO = DIFF_W'(-(2 ** (PEAK_W - 1)));

   logic [THR_W-1:0]      start_abs_ff;
   logic [THR_W-1:0]      end_abs_ff;
   logic [FACTOR_W-1:0]   start_factor_ff;
   logic [FACTOR_W-1:0]   end_factor_ff;
   logic [BASELINE_W-1:0] baseline_ff;
   logic [PED_RMS_W-1:0]  ped_rms_ff;
   logic [LEVEL_W-1:0]    start_level_ff;
   logic [LEVEL_W-1:0]    end_level_ff;

   logic [IDX_W-1:0]      idx_cnt_ff;
   logic                  stage_valid_ff;
   logic [ADC_BITS-1:0]   stage_adc_ff;
   logic                  stage_last_ff;
   logic [IDX_W-1:0]      stage_idx_ff;

   logic                  accept;
   logic                  win_last;
   logic [CMP_W-1:0]      scaled;
   logic signed [DIFF_W-1:0] diff;
   logic [IDX_W-1:0]      idx_dec;

   // threshold level from one absolute term and one sigma factor
   function automatic logic [LEVEL_W-1:0] level(input logic [THR_W-1:0] abs_thr,
                                                input logic [FACTOR_W-1:0] factor,
                                                input logic [BASELINE_W-1:0] mean,
                                                input logic [PED_RMS_W-1:0] rms);
      logic [PROD_W-1:0]  prod;
      logic [LEVEL_W-1:0] abs_s;
      logic [LEVEL_W-1:0] sig_s;
      prod  = PROD_W'(factor) * PROD_W'(rms);
      abs_s = LEVEL_W'(abs_thr) << SIGMA_FRAC;
      sig_s = LEVEL_W'(prod);
      return (LEVEL_W'(mean) << SIGMA_FRAC) + ((abs_s > sig_s) ? abs_s : sig_s);
   endfunction

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_abs_ff    <= START_ABS_RST;
         end_abs_ff      <= END_ABS_RST;
         start_factor_ff <= START_FACTOR_RST;
         end_factor_ff   <= END_FACTOR_RST;
         baseline_ff     <= BASELINE_RST;
         ped_rms_ff      <= PED_RMS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_ABS:    start_abs_ff    <= csr_write_data[THR_W-1:0];
            CSR_END_ABS:      end_abs_ff      <= csr_write_data[THR_W-1:0];
            CSR_START_FACTOR: start_factor_ff <= csr_write_data[FACTOR_W-1:0];
            CSR_END_FACTOR:   end_factor_ff   <= csr_write_data[FACTOR_W-1:0];
            CSR_BASELINE:     baseline_ff     <= csr_write_data[BASELINE_W-1:0];
            CSR_PED_RMS:      ped_rms_ff      <= csr_write_data[PED_RMS_W-1:0];
            default: ;
         endcase
      end
   end

   // recompute levels every cycle; a sample is compared while it sits in the stage register
   always_ff @(posedge clock) begin
      start_level_ff <= level(start_abs_ff, start_factor_ff, baseline_ff, ped_rms_ff);
      end_level_ff   <= level(end_abs_ff, end_factor_ff, baseline_ff, ped_rms_ff);
   end

   // intake handshake: hold while the stage is occupied and the queue is full
   assign req_stall = stage_valid_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign push      = stage_valid_ff && !q_stat.full;
   assign win_last  = req_window_end || (idx_cnt_ff == LAST_IDX);

   // advance stage valid and window index
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         idx_cnt_ff     <= '0;
      end else begin
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (push) begin
            stage_valid_ff <= 1'b0;
         end
         if (accept) begin
            idx_cnt_ff <= win_last ? '0 : idx_cnt_ff + IDX_W'(1);
         end
      end
   end

   // capture the sample
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_adc_ff  <= req_adc_sample;
         stage_last_ff <= win_last;
         stage_idx_ff  <= idx_cnt_ff;
      end
   end

   // classify against the levels and subtract the pedestal
   assign scaled  = CMP_W'(stage_adc_ff) << (FRAC_BITS + SIGMA_FRAC);
   assign diff    = signed'(DIFF_W'(stage_adc_ff) << FRAC_BITS) - signed'(DIFF_W'(baseline_ff));
   assign idx_dec = stage_idx_ff - IDX_W'(1);

   always_comb begin
      cls_ctl.ge_start = scaled >= CMP_W'(start_level_ff);
      cls_ctl.lt_end   = scaled < CMP_W'(end_level_ff);
      cls_ctl.last     = stage_last_ff;
      cls_ctl.idx      = IDX_OUT_W'(stage_idx_ff);
      // step the start back one sample unless that would reach zero
      if ({1'b0, stage_idx_ff} >= (IDX_W + 1)'(2)) begin
         cls_ctl.start_cand = IDX_OUT_W'(idx_dec);
      end else begin
         cls_ctl.start_cand = IDX_OUT_W'(stage_idx_ff);
      end
      // clamp to the peak field range
      if (diff > PEAK_HI) begin
         cls_ctl.peak = PEAK_HI[PEAK_W-1:0];
      end else if (diff < PEAK_LO) begin
         cls_ctl.peak = PEAK_LO[PEAK_W-1:0];
      end else begin
         cls_ctl.peak = diff[PEAK_W-1:0];
      end
   end

   assign cls_diff = diff;

endmodule

@@ rtl/tpf_queue.sv @@
// ----------------------------------------------------------------------------
// tpf_queue - short transaction queue
// Register-based FIFO that lets the classifier and the pulse back end
// stall independently.
// ----------------------------------------------------------------------------
module tpf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tpf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        wr_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        rd_data,
   output tpf_pkg::queue_stat_type stat
);
   import tpf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign stat.full  = count_ff == CNT_FULL;
   assign stat.empty = count_ff == '0;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_data    = entry_ff[rd_ptr_ff];

   // store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // advance pointers and track the fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

@@ rtl/tpf_back.sv @@
// ----------------------------------------------------------------------------
// tpf_back - pulse tracker and result register
// Opens and closes pulses from classified samples, accumulates area and
// peak, and presents one result transaction per closed pulse.
// ----------------------------------------------------------------------------
module tpf_back #(
   parameter int DIFF_W = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpf_pkg::queue_stat_type             q_stat,
   output logic                                pop,
   input  tpf_pkg::item_ctl_type               cls_ctl,
   input  logic signed [DIFF_W-1:0]            cls_diff,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tpf_pkg::IDX_OUT_W-1:0]       rsp_start_index,
   output logic [tpf_pkg::IDX_OUT_W-1:0]       rsp_end_index,
   output logic [tpf_pkg::IDX_OUT_W-1:0]       rsp_peak_index,
   output logic signed [tpf_pkg::PEAK_W-1:0]   rsp_peak_height,
   output logic signed [tpf_pkg::AREA_W-1:0]   rsp_pulse_area
);
   import tpf_pkg::*;

   localparam logic signed [AREA_W-1:0] AREA_HI = {1'b0, {(AREA_W - 1){1'b1}}};
   localparam logic signed [AREA_W-1:0] AREA_LO = {1'b1, {(AREA_W - 1){1'b0}}};

   logic                     in_pulse_ff;
   logic [IDX_OUT_W-1:0]     start_ff;
   logic [IDX_OUT_W-1:0]     max_idx_ff;
   logic signed [PEAK_W-1:0] max_height_ff;
   logic signed [AREA_W-1:0] area_ff;

   logic                     in_pulse_in;
   logic [IDX_OUT_W-1:0]     start_in;
   logic [IDX_OUT_W-1:0]     max_idx_in;
   logic signed [PEAK_W-1:0] max_height_in;
   logic signed [AREA_W-1:0] area_in;

   logic                     rsp_valid_ff;
   logic [IDX_OUT_W-1:0]     rsp_start_ff;
   logic [IDX_OUT_W-1:0]     rsp_end_ff;
   logic [IDX_OUT_W-1:0]     rsp_peak_idx_ff;
   logic signed [PEAK_W-1:0] rsp_peak_ff;
   logic signed [AREA_W-1:0] rsp_area_ff;

   logic                     fire;
   logic                     open_now;
   logic                     close_now;
   logic                     stay;
   logic                     keep;
   logic                     emit;
   logic [IDX_OUT_W-1:0]     pulse_start;
   logic signed [AREA_W:0]   sum;
   logic signed [AREA_W-1:0] area_acc;
   logic signed [PEAK_W-1:0] peak_new;
   logic                     bigger;
   logic [IDX_OUT_W-1:0]     max_idx_acc;
   logic signed [PEAK_W-1:0] max_height_acc;

   // take a transaction when the result register is free or draining
   assign fire = !q_stat.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = fire;

   // pulse decisions for the sample at the queue head
   assign open_now    = in_pulse_ff || cls_ctl.ge_start;
   assign pulse_start = in_pulse_ff ? start_ff : cls_ctl.start_cand;
   assign close_now   = open_now && cls_ctl.lt_end;
   assign stay        = open_now && !cls_ctl.lt_end;
   assign keep        = stay && !cls_ctl.last;
   assign emit        = close_now || (stay && cls_ctl.last);

   // saturating area and running peak
   assign sum = (AREA_W + 1)'(area_ff) + (AREA_W + 1)'(cls_diff);
   always_comb begin
      if (sum[AREA_W] != sum[AREA_W-1]) begin
         area_acc = sum[AREA_W] ? AREA_LO : AREA_HI;
      end else begin
         area_acc = sum[AREA_W-1:0];
      end
   end

   assign peak_new       = signed'(cls_ctl.peak);
   assign bigger         = peak_new > max_height_ff;
   assign max_height_acc = bigger ? peak_new : max_height_ff;
   assign max_idx_acc    = bigger ? cls_ctl.idx : max_idx_ff;

   // next pulse state: hold an open pulse, otherwise clear
   always_comb begin
      in_pulse_in   = keep;
      start_in      = keep ? pulse_start : '0;
      max_idx_in    = keep ? max_idx_acc : '0;
      max_height_in = keep ? max_height_acc : '0;
      area_in       = keep ? area_acc : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pulse_ff   <= 1'b0;
         start_ff      <= '0;
         max_idx_ff    <= '0;
         max_height_ff <= '0;
         area_ff       <= '0;
      end else if (fire) begin
         in_pulse_ff   <= in_pulse_in;
         start_ff      <= start_in;
         max_idx_ff    <= max_idx_in;
         max_height_ff <= max_height_in;
         area_ff       <= area_in;
      end
   end

   // result valid: set on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= emit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload: a closing sample reports the totals before it, a window-end sample still in the pulse is included
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_start_ff <= pulse_start;
         rsp_end_ff   <= cls_ctl.idx;
         if (close_now) begin
            rsp_peak_idx_ff <= max_idx_ff;
            rsp_peak_ff     <= max_height_ff;
            rsp_area_ff     <= area_ff;
         end else begin
            rsp_peak_idx_ff <= max_idx_acc;
            rsp_peak_ff     <= max_height_acc;
            rsp_area_ff     <= area_acc;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_index = rsp_start_ff;
   assign rsp_end_index   = rsp_end_ff;
   assign rsp_peak_index  = rsp_peak_idx_ff;
   assign rsp_peak_height = rsp_peak_ff;
   assign rsp_pulse_area  = rsp_area_ff;

endmodule

@@ test/tpf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpf_checker - scoreboard of the threshold pulse finder
// Watches the configuration port and both channels, keeps its own copy of
// the registers and of the pulse state, works out the pulse that each sample
// transaction closes and compares every result transaction with the oldest
// pulse still waiting.
// ----------------------------------------------------------------------------
module tpf_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [tpf_pkg::ADC_BITS_DEF-1:0]       req_adc_sample,
   input  logic                                   req_window_end,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [tpf_pkg::IDX_OUT_W-1:0]          rsp_start_index,
   input  logic [tpf_pkg::IDX_OUT_W-1:0]          rsp_end_index,
   input  logic [tpf_pkg::IDX_OUT_W-1:0]          rsp_peak_index,
   input  logic signed [tpf_pkg::PEAK_W-1:0]      rsp_peak_height,
   input  logic signed [tpf_pkg::AREA_W-1:0]      rsp_pulse_area,
   input  logic                                   csr_write_enable,
   input  logic [tpf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tpf_pkg::CSR_DATA_W-1:0]         csr_write_data,
   output int                                     fail_count,
   output int                                     pulses_pending,
   output int                                     pulses_checked,
   output int                                     samples_seen
);
   import tpf_pkg::*;

   localparam longint PEAK_TOP    = (longint'(1) << (PEAK_W - 1)) - 1;
   localparam longint PEAK_BOTTOM = -(longint'(1) << (PEAK_W - 1));
   localparam longint AREA_TOP    = (longint'(1) << (AREA_W - 1)) - 1;
   localparam longint AREA_BOTTOM = -(longint'(1) << (AREA_W - 1));

   typedef struct {
      logic [IDX_OUT_W-1:0]     start_index;
      logic [IDX_OUT_W-1:0]     end_index;
      logic [IDX_OUT_W-1:0]     peak_index;
      logic signed [PEAK_W-1:0] peak_height;
      logic signed [AREA_W-1:0] pulse_area;
   } pulse_type;

   // register copy
   logic [THR_W-1:0]      start_abs;
   logic [THR_W-1:0]      end_abs;
   logic [FACTOR_W-1:0]   start_factor;
   logic [FACTOR_W-1:0]   end_factor;
   logic [BASELINE_W-1:0] baseline;
   logic [PED_RMS_W-1:0]  ped_rms;

   // pulse state
   logic                  pulse_open;
   int                    window_pos;
   logic [IDX_OUT_W-1:0]  open_index;
   logic [IDX_OUT_W-1:0]  top_index;
   longint                top_height;
   longint                area_total;

   pulse_type expected_pulses[$];
   int        errors = 0;
   int        matched = 0;
   int        samples = 0;

   // threshold with FRAC_BITS + SIGMA_FRAC fraction bits
   function automatic longint unsigned trip_level(input logic [THR_W-1:0] abs_thr,
                                                  input logic [FACTOR_W-1:0] factor);
      longint unsigned abs_part;
      longint unsigned sigma_part;
      longint unsigned mean_part;
      abs_part   = longint'(abs_thr);
      abs_part   = abs_part << SIGMA_FRAC;
      sigma_part = longint'(factor);
      sigma_part = sigma_part * longint'(ped_rms);
      mean_part  = longint'(baseline);
      mean_part  = mean_part << SIGMA_FRAC;
      return mean_part + ((abs_part > sigma_part) ? abs_part : sigma_part);
   endfunction

   function automatic void clear_pulse();
      open_index = '0;
      top_index  = '0;
      top_height = 0;
      area_total = 0;
   endfunction

   function automatic void queue_pulse(input int end_at);
      pulse_type p;
      p.start_index = open_index;
      p.end_index   = end_at[IDX_OUT_W-1:0];
      p.peak_index  = top_index;
      p.peak_height = top_height[PEAK_W-1:0];
      p.pulse_area  = area_total[AREA_W-1:0];
      expected_pulses.insert(expected_pulses.size(), p);
   endfunction

   // advance the pulse state by one sample transaction
   function automatic void absorb_sample(input logic [ADC_BITS_DEF-1:0] adc,
                                         input logic window_end);
      longint unsigned scaled;
      longint          diff;
      longint          clipped;
      logic            last;
      int              idx;
      idx    = window_pos;
      last   = window_end || (window_pos >= WINDOW_SAMPLES_DEF - 1);
      scaled = longint'(adc);
      scaled = scaled << (FRAC_BITS_DEF + SIGMA_FRAC);
      diff   = longint'(scaled >> SIGMA_FRAC) - longint'(baseline);

      // open, shifting the start back by one past the first two indices
      if (!pulse_open && scaled >= trip_level(start_abs, start_factor)) begin
         pulse_open = 1'b1;
         open_index = IDX_OUT_W'((idx >= 2) ? idx - 1 : idx);
      end
      // close below the end level; the closing sample is not summed
      if (pulse_open && scaled < trip_level(end_abs, end_factor)) begin
         pulse_open = 1'b0;
         queue_pulse(idx);
         clear_pulse();
      end
      // accumulate area and track the first highest sample
      if (pulse_open) begin
         clipped = (diff > PEAK_TOP) ? PEAK_TOP : ((diff < PEAK_BOTTOM) ? PEAK_BOTTOM : diff);
         area_total = area_total + diff;
         if (area_total > AREA_TOP) area_total = AREA_TOP;
         if (area_total < AREA_BOTTOM) area_total = AREA_BOTTOM;
         if (top_height < clipped) begin
            top_height = clipped;
            top_index  = idx[IDX_OUT_W-1:0];
         end
      end
      // queue any open pulse and clear everything at the end of the window
      if (last) begin
         if (pulse_open) queue_pulse(idx);
         pulse_open = 1'b0;
         clear_pulse();
         window_pos = 0;
      end else begin
         window_pos = idx + 1;
      end
   endfunction

   function automatic void check_field(input string field, input longint want_v,
                                       input longint got_v);
      if (want_v != got_v) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : watch
      pulse_type want;
      if (reset) begin
         start_abs    = START_ABS_RST;
         end_abs      = END_ABS_RST;
         start_factor = START_FACTOR_RST;
         end_factor   = END_FACTOR_RST;
         baseline     = BASELINE_RST;
         ped_rms      = PED_RMS_RST;
         pulse_open   = 1'b0;
         window_pos   = 0;
         clear_pulse();
         expected_pulses.delete();
      end else begin
         // register writes; bits above a register's width are dropped
         if (csr_write_enable) begin
            case (csr_index)
               CSR_START_ABS:    start_abs    = csr_write_data[THR_W-1:0];
               CSR_END_ABS:      end_abs      = csr_write_data[THR_W-1:0];
               CSR_START_FACTOR: start_factor = csr_write_data[FACTOR_W-1:0];
               CSR_END_FACTOR:   end_factor   = csr_write_data[FACTOR_W-1:0];
               CSR_BASELINE:     baseline     = csr_write_data[BASELINE_W-1:0];
               CSR_PED_RMS:      ped_rms      = csr_write_data[PED_RMS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            absorb_sample(req_adc_sample, req_window_end);
            samples++;
         end
         // compare the result transaction with the oldest pulse waiting
         if (rsp_valid && !rsp_stall) begin
            if (expected_pulses.size() == 0) begin
               errors++;
               $display("%0t: pulse expected none actual start %0d end %0d", $time,
                        rsp_start_index, rsp_end_index);
            end else begin
               want = expected_pulses.pop_front();
               check_field("start_index", want.start_index, rsp_start_index);
               check_field("end_index", want.end_index, rsp_end_index);
               check_field("peak_index", want.peak_index, rsp_peak_index);
               check_field("peak_height", want.peak_height, rsp_peak_height);
               check_field("pulse_area", want.pulse_area, rsp_pulse_area);
               matched++;
            end
         end
      end
      fail_count     <= errors;
      pulses_pending <= expected_pulses.size();
      pulses_checked <= matched;
      samples_seen   <= samples;
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - regression of the threshold pulse finder
// Drives sample transactions with random gaps and stalls the result side at
// random. A short directed run covers threshold equality, pulses that open
// and close on one sample, window ends and the start index shift; random
// phases then sweep register settings, extremes included. The checker judges
// every result.
// ----------------------------------------------------------------------------
module testbench;
   import tpf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_SAMPLES = 720;

   typedef enum {SET_ZERO, SET_FULL, SET_RANDOM} setting_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [ADC_BITS_DEF-1:0]   req_adc_sample;
   logic                      req_window_end;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [IDX_OUT_W-1:0]      rsp_start_index;
   logic [IDX_OUT_W-1:0]      rsp_end_index;
   logic [IDX_OUT_W-1:0]      rsp_peak_index;
   logic signed [PEAK_W-1:0]  rsp_peak_height;
   logic signed [AREA_W-1:0]  rsp_pulse_area;
   logic                      csr_write_enable;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_write_data;

   int   fail_count;
   int   pulses_pending;
   int   pulses_checked;
   int   samples_seen;

   logic steady = 1'b0;
   int   stall_left = 0;
   int   stall_burst;
   int   shape_left = 0;
   int   shape_amp = 0;
   int   settings_loaded = 0;
   int   random_sent = 0;

   threshold_pulse_finder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .req_window_end   (req_window_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_index  (rsp_start_index),
      .rsp_end_index    (rsp_end_index),
      .rsp_peak_index   (rsp_peak_index),
      .rsp_peak_height  (rsp_peak_height),
      .rsp_pulse_area   (rsp_pulse_area),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tpf_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .req_window_end   (req_window_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_index  (rsp_start_index),
      .rsp_end_index    (rsp_end_index),
      .rsp_peak_index   (rsp_peak_index),
      .rsp_peak_height  (rsp_peak_height),
      .rsp_pulse_area   (rsp_pulse_area),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pulses_pending   (pulses_pending),
      .pulses_checked   (pulses_checked),
      .samples_seen     (samples_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #1_000_000;
      $display("threshold_pulse_finder regression: fail");
      $finish;
   end

   // idle length: mostly none, some short, a few long
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic int window_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(1, 3);
      return $urandom_range(4, 48);
   endfunction

   // baseline noise around base with occasional pulses and wild values
   function automatic int shaped_sample(input int base);
      int r;
      int value;
      r = $urandom_range(0, 99);
      if (r < 4) return $urandom_range(0, (1 << ADC_BITS_DEF) - 1);
      if (shape_left == 0 && r < 16) begin
         shape_left = $urandom_range(1, 10);
         shape_amp  = $urandom_range(1, 3000);
      end
      if (shape_left != 0) begin
         value = base + shape_amp - $urandom_range(0, shape_amp / 2);
         shape_left--;
      end else begin
         value = base + $urandom_range(0, 4) - 2;
      end
      if (value < 0) value = 0;
      if (value > (1 << ADC_BITS_DEF) - 1) value = (1 << ADC_BITS_DEF) - 1;
      return value;
   endfunction

   // stall the result side in random bursts
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_burst = gap_length();
         rsp_stall  <= (stall_burst != 0);
         stall_left <= (stall_burst != 0) ? stall_burst - 1 : 0;
      end
   end

   task automatic send_sample(input int adc, input logic last);
      int gap;
      gap = steady ? 0 : gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= adc[ADC_BITS_DEF-1:0];
      req_window_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold off until every pulse is out, then let the pipeline empty
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pulses_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] start_abs,
                                input logic [CSR_DATA_W-1:0] end_abs,
                                input logic [CSR_DATA_W-1:0] start_factor,
                                input logic [CSR_DATA_W-1:0] end_factor,
                                input logic [CSR_DATA_W-1:0] mean,
                                input logic [CSR_DATA_W-1:0] rms);
      csr_write(CSR_START_ABS, start_abs);
      csr_write(CSR_END_ABS, end_abs);
      csr_write(CSR_START_FACTOR, start_factor);
      csr_write(CSR_END_FACTOR, end_factor);
      csr_write(CSR_BASELINE, mean);
      csr_write(CSR_PED_RMS, rms);
      // an index past the map must change nothing
      csr_write(CSR_UNMAPPED, CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1)));
      csr_write_enable <= 1'b0;
      settings_loaded++;
   endtask

   // one register setting and a run of random windows under it
   task automatic run_phase(input setting_kind_type kind, input int length);
      logic [CSR_DATA_W-1:0] start_abs;
      logic [CSR_DATA_W-1:0] end_abs;
      logic [CSR_DATA_W-1:0] start_factor;
      logic [CSR_DATA_W-1:0] end_factor;
      logic [CSR_DATA_W-1:0] mean;
      logic [CSR_DATA_W-1:0] rms;
      int   win_left;
      int   n;
      logic last;
      case (kind)
         SET_ZERO: begin
            start_abs = '0; end_abs = '0; start_factor = '0;
            end_factor = '0; mean = '0; rms = '0;
         end
         SET_FULL: begin
            start_abs = '1; end_abs = '1; start_factor = '1;
            end_factor = '1; mean = '1; rms = '1;
         end
         default: begin
            start_abs    = CSR_DATA_W'($urandom_range(0, 3200));
            end_abs      = CSR_DATA_W'($urandom_range(0, 3200));
            // factors and rms carry junk above their width
            start_factor = CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1));
            end_factor   = CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1));
            mean         = CSR_DATA_W'(($urandom_range(0, 8000) << FRAC_BITS_DEF)
                           | $urandom_range(0, (1 << FRAC_BITS_DEF) - 1));
            rms          = CSR_DATA_W'(($urandom_range(0, 3) << PED_RMS_W)
                           | (($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 800)));
         end
      endcase
      load_settings(start_abs, end_abs, start_factor, end_factor, mean, rms);
      steady <= ($urandom_range(0, 3) == 0);
      win_left = window_length();
      for (n = 0; n < length; n++) begin
         win_left--;
         last = (win_left == 0) || (n == length - 1);
         send_sample(shaped_sample(int'(mean[BASELINE_W-1:0] >> FRAC_BITS_DEF)), last);
         if (win_left == 0) win_left = window_length();
      end
      random_sent += length;
      wait_for_drain();
      steady <= 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_adc_sample   = '0;
      req_window_end   = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_START_ABS;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: both levels at 3 counts
      send_sample(0, 1'b0);
      send_sample(5, 1'b0);                       // opens at index 1, no shift
      send_sample((1 << ADC_BITS_DEF) - 1, 1'b0); // full-scale peak
      send_sample(2, 1'b0);                       // closes
      send_sample(2, 1'b0);
      send_sample(3, 1'b0);                       // opens exactly at the level
      send_sample(3, 1'b1);                       // still open at window end
      send_sample(10, 1'b0);                      // opens at index 0
      send_sample(0, 1'b0);
      send_sample(7, 1'b0);
      send_sample(9, 1'b1);
      wait_for_drain();

      // end level above start level: open and close on one sample
      load_settings(18'd16, 18'd160, 18'd0, 18'd0, 18'd0, 18'd0);
      send_sample(5, 1'b0);
      send_sample(5, 1'b0);
      send_sample(12, 1'b1);
      wait_for_drain();

      // zero thresholds over a pedestal: samples at the pedestal add nothing
      load_settings(18'd0, 18'd0, 18'd0, 18'd0, 18'd160, 18'd1000);
      send_sample(10, 1'b0);
      send_sample(10, 1'b0);
      send_sample(11, 1'b0);
      send_sample(9, 1'b0);
      send_sample(9, 1'b1);
      wait_for_drain();

      // sigma terms dominate the absolute ones
      load_settings(18'd0, 18'd0, 18'd255, 18'd16, 18'd0, 18'd16);
      send_sample(15, 1'b0);
      send_sample(16, 1'b0);
      send_sample(1, 1'b0);
      send_sample(0, 1'b1);
      wait_for_drain();

      // random phases, starting with both register extremes
      run_phase(SET_ZERO, $urandom_range(60, 140));
      run_phase(SET_FULL, $urandom_range(60, 140));
      while (random_sent < RANDOM_SAMPLES) run_phase(SET_RANDOM, $urandom_range(60, 140));

      $display("Covered %0d samples and %0d pulses over %0d register settings,",
               samples_seen, pulses_checked, settings_loaded);
      $display("register extremes and junk above register widths included.");
      if (fail_count == 0 && pulses_pending == 0) begin
         $display("threshold_pulse_finder regression: pass");
      end else begin
         $display("threshold_pulse_finder regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/tpf_pkg.sv
rtl/tpf_front.sv
rtl/tpf_queue.sv
rtl/tpf_back.sv
rtl/threshold_pulse_finder.sv
test/tpf_checker.sv
test/testbench.sv
